[rtl/awt_pkg.sv]
`default_nettype none

package awt_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 18;
	localparam int NUM_REG_COEFS = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int PEAK_W        = 24;
	localparam int Y_W           = 28;
	localparam int SUM_W         = 54;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 64;
	localparam int QUO_W         = 16;
	localparam int NUM_W         = Y_W + QUO_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = 3'd6;

	localparam logic signed [COEF_W-1:0] COEF_ONE_RESET = 18'sd16384;
	localparam logic [PEAK_W-1:0] PEAK_ONE = 24'h040000;
	localparam logic [PEAK_W-1:0] PEAK_MAX = 24'hFFFFFF;

	localparam logic signed [MUL_W-1:0] Q30_ONE = 32'sh4000_0000;
	localparam logic signed [MUL_W-1:0] SIN_A1  = 32'sd1686629713;
	localparam logic signed [MUL_W-1:0] SIN_A3  = 32'sd693598668;
	localparam logic signed [MUL_W-1:0] SIN_A5  = 32'sd85569306;
	localparam logic signed [MUL_W-1:0] SIN_A7  = 32'sd5026995;
	localparam logic signed [MUL_W-1:0] SIN_A9  = 32'sd172272;

	localparam logic [SAMPLE_W-1:0] OUT_POS_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] OUT_NEG_MAX = 16'h8000;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_arr_t [NUM_REG_COEFS];

	typedef enum logic [4:0] {
		OP_NOP,
		OP_REBUILD,
		OP_ENTRY_START,
		OP_MUL_CX,
		OP_MUL_XX,
		OP_ADD_P,
		OP_SET_XX,
		OP_SIN_START,
		OP_MUL_ZZ,
		OP_SET_Z2,
		OP_MUL_HORN,
		OP_HORN,
		OP_MUL_ZACC,
		OP_SET_SIN,
		OP_MUL_CACC,
		OP_ROUND_Y,
		OP_PEAK,
		OP_DIV_START,
		OP_DIV_STEP
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_P_MUL_CX,
		ST_P_ADD,
		ST_P_MUL_XX,
		ST_P_SET_XX,
		ST_H_START,
		ST_H_MUL_ZZ,
		ST_H_SET_Z2,
		ST_H_MUL_HORN,
		ST_H_HORN,
		ST_H_MUL_ZACC,
		ST_H_SET_SIN,
		ST_H_MUL_CACC,
		ST_H_ADD,
		ST_FINISH,
		ST_PEAK,
		ST_DIV_START,
		ST_DIV_STEP,
		ST_WRITE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] horn;
		logic [2:0] term;
	} dp_cmd_t;

	typedef struct packed {
		logic we;
		logic lookup_en;
	} tbl_cmd_t;

	// Arithmetic shift right with rounding half away from zero.
	function automatic logic signed [PROD_W-1:0] round_shr(
		input logic signed [PROD_W-1:0] v,
		input int sh
	);
		logic signed [PROD_W-1:0] bias;
		bias = (64'sd1 <<< (sh - 1)) - (v[PROD_W-1] ? 64'sd1 : 64'sd0);
		return (v + bias) >>> sh;
	endfunction

endpackage

`default_nettype wire

[rtl/awt_dp.sv]
`default_nettype none

module awt_dp #(
	parameter int TABLE_SIZE = 512,
	parameter int IW = $clog2(TABLE_SIZE)
) (
	input  wire                                clk,
	input  awt_pkg::dp_cmd_t                   cmd,
	input  wire [IW-1:0]                       entry_idx,
	input  awt_pkg::coef_arr_t                 coefs,
	output logic signed [awt_pkg::SAMPLE_W-1:0] entry_val
);
	import awt_pkg::*;

	localparam int HALF  = TABLE_SIZE / 2;
	localparam int XSH   = 30 - (IW - 1);
	localparam int PH_SH = 30 - (IW - 2);

	logic signed [IW:0]        rel;
	logic signed [MUL_W-1:0]   x_new;
	coef_t                     coef_sel;
	logic signed [MUL_W-1:0]   coef_w;
	logic [4:0]                hmul;
	logic [IW+4:0]             ph_full;
	logic [IW-1:0]             ph;
	logic [29:0]               f;
	logic signed [MUL_W-1:0]   z_new;
	logic signed [MUL_W-1:0]   horn_k;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  rnd_full;
	logic signed [MUL_W-1:0]   rnd32;
	logic signed [PROD_W-1:0]  yr_full;
	logic [Y_W-1:0]            ymag;
	logic [NUM_W-1:0]          num;
	logic [NUM_W-1:0]          d2;

	logic signed [MUL_W-1:0]   x_q;
	logic signed [MUL_W-1:0]   xx_q;
	logic signed [MUL_W-1:0]   z_q;
	logic signed [MUL_W-1:0]   z2_q;
	logic signed [MUL_W-1:0]   acc_q;
	logic                      zneg_q;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [Y_W-1:0]     y_q;
	logic [PEAK_W-1:0]         peak_q;
	logic [NUM_W-1:0]          rem_q;
	logic [NUM_W-1:0]          dv_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      ovf_q;

	always_comb begin
		rel      = $signed({1'b0, entry_idx}) - $signed((IW + 1)'(HALF));
		x_new    = MUL_W'(rel) <<< XSH;
		coef_sel = (cmd.term < NUM_REG_COEFS) ? coefs[cmd.term] : '0;
		coef_w   = MUL_W'(coef_sel);
		// Harmonic multiple 1+3k and its phase, wrapped to one period.
		hmul     = 5'(1 + 3 * cmd.term);
		ph_full  = (IW + 5)'(rel[IW-1:0]) * (IW + 5)'(hmul);
		ph       = ph_full[IW-1:0];
		f        = 30'(ph[IW-3:0]) << PH_SH;
		z_new    = ph[IW-2] ? (Q30_ONE - {2'b00, f}) : {2'b00, f};
		rnd_full = round_shr(p_q, 30);
		rnd32    = rnd_full[MUL_W-1:0];
		yr_full  = round_shr(PROD_W'(sum_q), 26);
		ymag     = y_q[Y_W-1] ? Y_W'(-y_q) : Y_W'(y_q);
		num      = {1'b0, ymag, {QUO_W{1'b0}}} + NUM_W'(peak_q);
		d2       = NUM_W'({peak_q, 1'b0});
	end

	always_comb begin
		unique case (cmd.horn)
			2'd0: horn_k = SIN_A7;
			2'd1: horn_k = SIN_A5;
			2'd2: horn_k = SIN_A3;
			default: horn_k = SIN_A1;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_CX: begin
				mul_a = coef_w;
				mul_b = xx_q;
			end
			OP_MUL_XX: begin
				mul_a = xx_q;
				mul_b = x_q;
			end
			OP_MUL_ZZ: begin
				mul_a = z_q;
				mul_b = z_q;
			end
			OP_MUL_HORN: begin
				mul_a = z2_q;
				mul_b = acc_q;
			end
			OP_MUL_ZACC: begin
				mul_a = z_q;
				mul_b = acc_q;
			end
			OP_MUL_CACC: begin
				mul_a = coef_w;
				mul_b = acc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_REBUILD: peak_q <= PEAK_ONE;
			OP_ENTRY_START: begin
				x_q   <= x_new;
				xx_q  <= x_new;
				sum_q <= '0;
			end
			OP_ADD_P: sum_q <= sum_q + SUM_W'(p_q);
			OP_SET_XX: xx_q <= rnd32;
			OP_SIN_START: begin
				z_q    <= z_new;
				zneg_q <= ph[IW-1];
			end
			OP_SET_Z2: begin
				z2_q  <= rnd32;
				acc_q <= SIN_A9;
			end
			OP_HORN: acc_q <= horn_k - rnd32;
			OP_SET_SIN: acc_q <= zneg_q ? -rnd32 : rnd32;
			OP_ROUND_Y: y_q <= yr_full[Y_W-1:0];
			OP_PEAK: begin
				if (ymag > Y_W'(peak_q)) begin
					peak_q <= (ymag > Y_W'(PEAK_MAX)) ? PEAK_MAX : ymag[PEAK_W-1:0];
				end
			end
			OP_DIV_START: begin
				rem_q <= num;
				dv_q  <= d2 << (QUO_W - 1);
				ovf_q <= num >= (d2 << QUO_W);
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (y_q[Y_W-1]) begin
			entry_val = (ovf_q || quo_q > OUT_NEG_MAX) ? OUT_NEG_MAX : -quo_q;
		end else begin
			entry_val = (ovf_q || quo_q > OUT_POS_MAX) ? OUT_POS_MAX : quo_q;
		end
	end

endmodule

`default_nettype wire

[rtl/awt_ctrl.sv]
`default_nettype none

module awt_ctrl #(
	parameter int TABLE_SIZE = 512,
	parameter int NUM_COEFS = 6,
	parameter int IW = $clog2(TABLE_SIZE)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                wave_mode,
	input  wire                sample_in_valid,
	output awt_pkg::dp_cmd_t   dp_cmd,
	output awt_pkg::tbl_cmd_t  tbl_cmd,
	output logic [IW-1:0]      entry_idx
);
	import awt_pkg::*;

	localparam int KW = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(NUM_COEFS - 1);
	localparam logic [IW-1:0] I_LAST = IW'(TABLE_SIZE - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] i_q, i_d;
	logic [KW-1:0] k_q, k_d;
	logic [3:0]    step_q, step_d;
	logic          pass_q, pass_d;
	logic          stale_q;
	logic          done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			step_q  <= '0;
			pass_q  <= 1'b0;
			stale_q <= 1'b1;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			k_q     <= k_d;
			step_q  <= step_d;
			pass_q  <= pass_d;
			if (cfg_we) begin
				stale_q <= 1'b1;
			end else if (done) begin
				stale_q <= 1'b0;
			end
		end
	end

	assign entry_idx = i_q;

	always_comb begin
		state_d           = state_q;
		i_d               = i_q;
		k_d               = k_q;
		step_d            = step_q;
		pass_d            = pass_q;
		done              = 1'b0;
		dp_cmd.op         = OP_NOP;
		dp_cmd.horn       = step_q[1:0];
		dp_cmd.term       = 3'(k_q);
		tbl_cmd.we        = 1'b0;
		tbl_cmd.lookup_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tbl_cmd.lookup_en = !stale_q;
				if (stale_q && sample_in_valid) begin
					dp_cmd.op = OP_REBUILD;
					i_d       = '0;
					pass_d    = 1'b0;
					state_d   = ST_ENTRY;
				end
			end
			ST_ENTRY: begin
				dp_cmd.op = OP_ENTRY_START;
				k_d       = '0;
				state_d   = wave_mode ? ST_P_MUL_CX : ST_H_START;
			end
			ST_P_MUL_CX: begin
				dp_cmd.op = OP_MUL_CX;
				state_d   = ST_P_ADD;
			end
			ST_P_ADD: begin
				dp_cmd.op = OP_ADD_P;
				state_d   = (k_q == K_LAST) ? ST_FINISH : ST_P_MUL_XX;
			end
			ST_P_MUL_XX: begin
				dp_cmd.op = OP_MUL_XX;
				state_d   = ST_P_SET_XX;
			end
			ST_P_SET_XX: begin
				dp_cmd.op = OP_SET_XX;
				k_d       = k_q + 1'b1;
				state_d   = ST_P_MUL_CX;
			end
			ST_H_START: begin
				dp_cmd.op = OP_SIN_START;
				state_d   = ST_H_MUL_ZZ;
			end
			ST_H_MUL_ZZ: begin
				dp_cmd.op = OP_MUL_ZZ;
				state_d   = ST_H_SET_Z2;
			end
			ST_H_SET_Z2: begin
				dp_cmd.op = OP_SET_Z2;
				step_d    = '0;
				state_d   = ST_H_MUL_HORN;
			end
			ST_H_MUL_HORN: begin
				dp_cmd.op = OP_MUL_HORN;
				state_d   = ST_H_HORN;
			end
			ST_H_HORN: begin
				dp_cmd.op = OP_HORN;
				step_d    = step_q + 1'b1;
				state_d   = (step_q[1:0] == 2'd3) ? ST_H_MUL_ZACC : ST_H_MUL_HORN;
			end
			ST_H_MUL_ZACC: begin
				dp_cmd.op = OP_MUL_ZACC;
				state_d   = ST_H_SET_SIN;
			end
			ST_H_SET_SIN: begin
				dp_cmd.op = OP_SET_SIN;
				state_d   = ST_H_MUL_CACC;
			end
			ST_H_MUL_CACC: begin
				dp_cmd.op = OP_MUL_CACC;
				state_d   = ST_H_ADD;
			end
			ST_H_ADD: begin
				dp_cmd.op = OP_ADD_P;
				if (k_q == K_LAST) begin
					state_d = ST_FINISH;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_H_START;
				end
			end
			ST_FINISH: begin
				dp_cmd.op = OP_ROUND_Y;
				state_d   = pass_q ? ST_DIV_START : ST_PEAK;
			end
			ST_PEAK: begin
				dp_cmd.op = OP_PEAK;
				state_d   = ST_ENTRY;
				if (i_q == I_LAST) begin
					i_d    = '0;
					pass_d = 1'b1;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			ST_DIV_START: begin
				dp_cmd.op = OP_DIV_START;
				step_d    = '0;
				state_d   = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				dp_cmd.op = OP_DIV_STEP;
				step_d    = step_q + 1'b1;
				if (step_q == 4'd15) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				tbl_cmd.we = 1'b1;
				if (i_q == I_LAST) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_ENTRY;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[rtl/awt_table.sv]
`default_nettype none

module awt_table #(
	parameter int TABLE_SIZE = 512,
	parameter int IW = $clog2(TABLE_SIZE)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  awt_pkg::tbl_cmd_t                   cmd,
	input  wire [IW-1:0]                        waddr,
	input  wire signed [awt_pkg::SAMPLE_W-1:0]  wdata,
	input  wire                                 sample_in_valid,
	output logic                                sample_in_ready,
	input  wire signed [awt_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                sample_out_valid,
	input  wire                                 sample_out_ready,
	output logic signed [awt_pkg::SAMPLE_W-1:0] sample_out
);
	import awt_pkg::*;

	localparam int HALF = TABLE_SIZE / 2;
	// Q2.14 times HALF over 2^14 is a shift toward zero.
	localparam int SH = 14 - (IW - 1);

	logic [SAMPLE_W-1:0] shape_table_q [TABLE_SIZE];
	logic signed [16:0]  s_adj;
	logic signed [16:0]  idx_full;
	logic [IW-1:0]       raddr;
	logic                advance;
	logic                accept;
	logic [SAMPLE_W-1:0] rd_s1;
	logic                valid_s1;

	always_comb begin
		s_adj    = 17'(sample_in) + (sample_in[SAMPLE_W-1] ? 17'((1 << SH) - 1) : 17'sd0);
		idx_full = (s_adj >>> SH) + 17'(HALF);
		if (idx_full[16]) begin
			raddr = '0;
		end else if (idx_full > 17'(TABLE_SIZE - 1)) begin
			raddr = IW'(TABLE_SIZE - 1);
		end else begin
			raddr = idx_full[IW-1:0];
		end
	end

	assign advance         = !sample_out_valid || sample_out_ready;
	assign sample_in_ready = cmd.lookup_en && advance;
	assign accept          = sample_in_valid && sample_in_ready;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			shape_table_q[waddr] <= wdata;
		end
		if (accept) begin
			rd_s1 <= shape_table_q[raddr];
		end
		if (advance && valid_s1) begin
			sample_out <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			sample_out_valid <= 1'b0;
		end else if (advance) begin
			valid_s1         <= accept;
			sample_out_valid <= valid_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/audio_waveshaper_table_core.sv]
`default_nettype none

// Waveshaper lookup: each Q2.14 sample picks entry trunc(sample*TABLE_SIZE/2)+TABLE_SIZE/2
// (clamped) of a table and returns it as Q1.15. While the table is current and the
// output is not stalled one word is accepted per cycle; its result passes through the
// rd_s1 and sample_out registers. The table is built from the configuration by a
// controller that sequences one shared 32x32 multiplier and a bit-serial divider; a
// rebuild starts when a word arrives after reset or after any configuration write to a
// valid index, and then holds the input in polynomial or harmonic mode for two passes:
// peak search, then normalize and store. TABLE_SIZE must be a power of two.
module audio_waveshaper_table_core #(
	parameter int TABLE_SIZE = 512,
	parameter int NUM_COEFS = 6
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [awt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [awt_pkg::COEF_W-1:0]            cfg_data,
	input  wire                                  sample_in_valid,
	output logic                                 sample_in_ready,
	input  wire signed [awt_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                 sample_out_valid,
	input  wire                                  sample_out_ready,
	output logic signed [awt_pkg::SAMPLE_W-1:0]  sample_out
);
	import awt_pkg::*;

	localparam int IW = $clog2(TABLE_SIZE);

	logic                    wave_mode_q;
	coef_arr_t               coefs_q;
	logic                    cfg_hit;
	dp_cmd_t                 dp_cmd;
	tbl_cmd_t                tbl_cmd;
	logic [IW-1:0]           entry_idx;
	logic signed [SAMPLE_W-1:0] entry_val;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_WAVE_MODE ||
		(cfg_index >= CFG_COEF_FIRST && cfg_index <= CFG_COEF_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= 1'b1;
			for (int k = 0; k < NUM_REG_COEFS; k++) begin
				coefs_q[k] <= (k == 0) ? COEF_ONE_RESET : '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WAVE_MODE) begin
				wave_mode_q <= cfg_data[0];
			end
			for (int k = 0; k < NUM_REG_COEFS; k++) begin
				if (cfg_index == CFG_COEF_FIRST + CFG_IDX_W'(k)) begin
					coefs_q[k] <= cfg_data;
				end
			end
		end
	end

	awt_ctrl #(
		.TABLE_SIZE(TABLE_SIZE),
		.NUM_COEFS (NUM_COEFS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_hit),
		.wave_mode      (wave_mode_q),
		.sample_in_valid(sample_in_valid),
		.dp_cmd         (dp_cmd),
		.tbl_cmd        (tbl_cmd),
		.entry_idx      (entry_idx)
	);

	awt_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk      (clk),
		.cmd      (dp_cmd),
		.entry_idx(entry_idx),
		.coefs    (coefs_q),
		.entry_val(entry_val)
	);

	awt_table #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_table (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (tbl_cmd),
		.waddr           (entry_idx),
		.wdata           (entry_val),
		.sample_in_valid (sample_in_valid),
		.sample_in_ready (sample_in_ready),
		.sample_in       (sample_in),
		.sample_out_valid(sample_out_valid),
		.sample_out_ready(sample_out_ready),
		.sample_out      (sample_out)
	);

endmodule

`default_nettype wire
